[hdl/b64u_pkg.sv]
// ----------------------------------------------------------------------------
// b64u_pkg
// Shared types, constants and alphabet functions of the unpadded url-safe
// base64 codec.
// ----------------------------------------------------------------------------
package b64u_pkg;

    localparam int unsigned DATA_W  = 8;
    localparam int unsigned SEXT_W  = 6;
    localparam int unsigned LIMIT_W = 16;
    localparam int unsigned CFG_A_W = 1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

    // configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_DECODE_MODE  = 1'b0;
    localparam logic [CFG_A_W-1:0] REG_OUTPUT_LIMIT = 1'b1;

    // per-frame state
    typedef struct packed {
        logic [1:0]         phase;
        logic [SEXT_W-1:0]  carry;
        logic [SEXT_W-1:0]  first;
        logic               stopped;
        logic [LIMIT_W-1:0] count;
    } b64u_state_t;

    // one result request
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              valid;
        logic              last;
    } b64u_res_t;

    // results of one input request, up to two
    typedef struct packed {
        logic [1:0] n;
        b64u_res_t  r0;
        b64u_res_t  r1;
    } b64u_out_t;

    // sextet value to alphabet character
    function automatic logic [DATA_W-1:0] sextet_to_char(input logic [SEXT_W-1:0] v);
        logic [DATA_W-1:0] w;
        w = {2'b00, v};
        if (v < 6'd26)      return w + 8'd65;
        else if (v < 6'd52) return w + 8'd71;
        else if (v < 6'd62) return w - 8'd4;
        else if (v == 6'd62) return 8'h2D;
        else                return 8'h5F;
    endfunction

    // character to {ok, sextet}; '+' and '/' also map to 62 and 63; ok low for any other character
    function automatic logic [SEXT_W:0] char_to_sextet(input logic [DATA_W-1:0] ch);
        logic [DATA_W-1:0] d;
        d = 8'd0;
        if (ch inside {[8'h41:8'h5A]}) begin
            d = ch - 8'h41;
            return {1'b1, d[SEXT_W-1:0]};
        end else if (ch inside {[8'h61:8'h7A]}) begin
            d = ch - 8'd71;
            return {1'b1, d[SEXT_W-1:0]};
        end else if (ch inside {[8'h30:8'h39]}) begin
            d = ch + 8'd4;
            return {1'b1, d[SEXT_W-1:0]};
        end else if (ch == 8'h2D || ch == 8'h2B) begin
            return {1'b1, 6'd62};
        end else if (ch == 8'h5F || ch == 8'h2F) begin
            return {1'b1, 6'd63};
        end else begin
            return {1'b0, 6'd0};
        end
    endfunction

endpackage

[hdl/b64u_step.sv]
// ----------------------------------------------------------------------------
// b64u_step
// Combinational step: one registered input request and the frame state give
// the next frame state and up to two result requests.
// ----------------------------------------------------------------------------
module b64u_step (
    input  logic                                decode_mode,
    input  logic [b64u_pkg::LIMIT_W-1:0]        output_limit,
    input  b64u_pkg::b64u_state_t               state_cur,
    input  logic [b64u_pkg::DATA_W-1:0]         in_data,
    input  logic                                in_last,
    output b64u_pkg::b64u_state_t               state_nxt,
    output b64u_pkg::b64u_out_t                 res
);

    // encode side
    logic [1:0]                       enc_p;
    logic [1:0]                       enc_np;
    logic [b64u_pkg::SEXT_W-1:0]      enc_carry;
    logic [b64u_pkg::DATA_W-1:0]      enc_c0;
    logic [b64u_pkg::DATA_W-1:0]      enc_c1;
    logic                             enc_two;

    // decode side
    logic [b64u_pkg::SEXT_W:0]        dec_lookup;
    logic                             dec_ok;
    logic [b64u_pkg::SEXT_W-1:0]      dec_s;
    logic                             dec_try;
    logic                             dec_emit;
    logic [b64u_pkg::DATA_W-1:0]      dec_byte;
    logic [b64u_pkg::LIMIT_W:0]       dec_cnt_inc;

    always_comb begin
        enc_p     = (state_cur.phase == 2'd3) ? 2'd0 : state_cur.phase;
        enc_c1    = b64u_pkg::sextet_to_char(in_data[5:0]);
        enc_two   = 1'b0;
        case (enc_p)
            2'd0: begin
                enc_c0    = b64u_pkg::sextet_to_char(in_data[7:2]);
                enc_carry = {in_data[1:0], 4'b0000};
                enc_np    = 2'd1;
            end
            2'd1: begin
                enc_c0    = b64u_pkg::sextet_to_char(state_cur.carry | {2'b00, in_data[7:4]});
                enc_carry = {in_data[3:0], 2'b00};
                enc_np    = 2'd2;
            end
            default: begin
                enc_c0    = b64u_pkg::sextet_to_char(state_cur.carry | {4'b0000, in_data[7:6]});
                enc_carry = '0;
                enc_np    = 2'd0;
                enc_two   = 1'b1;
            end
        endcase
    end

    always_comb begin
        dec_lookup  = b64u_pkg::char_to_sextet(in_data);
        dec_ok      = dec_lookup[b64u_pkg::SEXT_W];
        dec_s       = dec_lookup[b64u_pkg::SEXT_W-1:0];
        dec_cnt_inc = {1'b0, state_cur.count} + 17'd1;
        if (!dec_ok) begin
            dec_byte = {state_cur.first, 2'b11};
            dec_try  = (state_cur.phase == 2'd1);
        end else begin
            case (state_cur.phase)
                2'd0: begin
                    // lone sextet at frame end
                    dec_byte = {dec_s, 2'b11};
                    dec_try  = in_last;
                end
                2'd1: begin
                    dec_byte = {state_cur.first, dec_s[5:4]};
                    dec_try  = 1'b1;
                end
                2'd2: begin
                    dec_byte = {state_cur.carry[3:0], dec_s[5:2]};
                    dec_try  = 1'b1;
                end
                default: begin
                    dec_byte = {state_cur.carry[1:0], dec_s};
                    dec_try  = 1'b1;
                end
            endcase
        end
        dec_try  = dec_try && !state_cur.stopped;
        dec_emit = dec_try && (state_cur.count < output_limit);
    end

    always_comb begin
        state_nxt = state_cur;
        res       = '0;
        if (!decode_mode) begin
            res.r0 = '{data: enc_c0, valid: 1'b1, last: 1'b0};
            if (enc_two) begin
                res.r1 = '{data: enc_c1, valid: 1'b1, last: in_last};
                res.n  = 2'd2;
            end else if (in_last && enc_np != 2'd0) begin
                res.r1 = '{data: b64u_pkg::sextet_to_char(enc_carry), valid: 1'b1,
                           last: 1'b1};
                res.n  = 2'd2;
            end else begin
                res.r0.last = in_last;
                res.n       = 2'd1;
            end
            state_nxt.phase = enc_np;
            state_nxt.carry = enc_carry;
        end else begin
            if (dec_emit) begin
                res.r0 = '{data: dec_byte, valid: 1'b1, last: in_last};
                res.n  = 2'd1;
            end else if (in_last) begin
                res.r0 = '{data: '0, valid: 1'b0, last: 1'b1};
                res.n  = 2'd1;
            end
            if (!state_cur.stopped) begin
                if (!dec_ok) begin
                    state_nxt.stopped = 1'b1;
                end else begin
                    state_nxt.phase = state_cur.phase + 2'd1;
                    case (state_cur.phase)
                        2'd0:    state_nxt.first = dec_s;
                        2'd3:    state_nxt.carry = '0;
                        default: state_nxt.carry = dec_s;
                    endcase
                end
                if (dec_emit) begin
                    state_nxt.count = dec_cnt_inc[b64u_pkg::LIMIT_W-1:0];
                    if (dec_cnt_inc >= {1'b0, output_limit}) state_nxt.stopped = 1'b1;
                end else if (dec_try) begin
                    state_nxt.stopped = 1'b1;
                end
            end
        end
        if (in_last) state_nxt = '0;
    end

endmodule

[hdl/url_safe_base64_codec_unit.sv]
// ----------------------------------------------------------------------------
// url_safe_base64_codec_unit
// Unpadded url-safe base64 encoder / decoder over framed byte streams.
// ----------------------------------------------------------------------------
// a request accepted into the input register is worked into the result buffer once that buffer
// has room; one input request per cycle while each gives at most one result and m_tready is high;
//   an encode request that gives two characters holds the next request until the single result
//   port has taken the first of the two from the two-entry result buffer
// reset (aresetn low, synchronous): encode mode, output limit 65535, frame
//   state cleared, input register and result buffer emptied
module url_safe_base64_codec_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [b64u_pkg::CFG_A_W-1:0]     cfg_addr,
    input  logic [b64u_pkg::LIMIT_W-1:0]     cfg_wdata,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] in_data
    input  logic                             s_tlast,   // frame_last
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // [7:0] out_data
    output logic                             m_tuser,   // [0] data_valid
    output logic                             m_tlast    // frame_end
);

    // configuration registers
    logic                                decode_mode_reg;
    logic [b64u_pkg::LIMIT_W-1:0]        output_limit_reg;

    // frame state
    b64u_pkg::b64u_state_t               state_reg;
    b64u_pkg::b64u_state_t               state_next;

    // input register
    logic                                in_valid_reg;
    logic [b64u_pkg::DATA_W-1:0]         in_data_reg;
    logic                                in_last_reg;

    // two-entry result buffer, slot0 at the port
    b64u_pkg::b64u_res_t                 slot0_reg;
    b64u_pkg::b64u_res_t                 slot1_reg;
    logic [1:0]                          buf_cnt_reg;

    b64u_pkg::b64u_out_t                 step_out;
    logic                                pop;
    logic                                fire;

    b64u_step u_step (
        .decode_mode  (decode_mode_reg),
        .output_limit (output_limit_reg),
        .state_cur    (state_reg),
        .in_data      (in_data_reg),
        .in_last      (in_last_reg),
        .state_nxt    (state_next),
        .res          (step_out)
    );

    // a result leaves on every port handshake
    assign pop  = (buf_cnt_reg != 2'd0) && m_tready;
    // the held request is worked once the buffer is empty by the next edge
    assign fire = in_valid_reg &&
                  ((buf_cnt_reg == 2'd0) || (buf_cnt_reg == 2'd1 && m_tready));

    // input register frees up whenever its request is worked
    assign s_tready = !in_valid_reg || fire;

    assign m_tvalid = (buf_cnt_reg != 2'd0);
    assign m_tdata  = slot0_reg.data;
    assign m_tuser  = slot0_reg.valid;
    assign m_tlast  = slot0_reg.last;

    // configuration and frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decode_mode_reg  <= 1'b0;
            output_limit_reg <= b64u_pkg::LIMIT_RESET;
            state_reg        <= '0;
        end else begin
            if (cfg_wr_en && cfg_addr == b64u_pkg::REG_DECODE_MODE) begin
                decode_mode_reg <= cfg_wdata[0];
                // a mode change drops any partial frame
                state_reg       <= '0;
            end else if (fire) begin
                state_reg <= state_next;
            end
            if (cfg_wr_en && cfg_addr == b64u_pkg::REG_OUTPUT_LIMIT) begin
                output_limit_reg <= cfg_wdata;
            end
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // result buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_cnt_reg <= 2'd0;
        end else if (fire) begin
            buf_cnt_reg <= step_out.n;
        end else if (pop) begin
            buf_cnt_reg <= buf_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            slot0_reg <= step_out.r0;
            slot1_reg <= step_out.r1;
        end else if (pop) begin
            slot0_reg <= slot1_reg;
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // the result buffer holds two entries at most
    a_buf_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        buf_cnt_reg != 2'd3)
        else $error("result buffer count out of range");

    // an empty marker only closes a frame and carries zero data
    a_marker_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tlast && m_tdata == 8'd0))
        else $error("empty marker not at frame end");

    // decoding never gives two results for one request
    a_dec_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && decode_mode_reg) |-> (step_out.n != 2'd2))
        else $error("decode produced two results");

    // a worked request never lands on unread results
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && step_out.n != 2'd0) |=> (buf_cnt_reg == $past(step_out.n)))
        else $error("result buffer count lost");

endmodule
